// File: rtl/ttce_pkg.sv
// Shared types, codes and constants of the text terminal cursor engine.
package ttce_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;
	localparam int FIFO_DEPTH  = 4;

	// Widest cell address over the whole parameter range (256 x 64 cells).
	localparam int ADDR_W_MAX  = 14;

	localparam int MODE_W = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int ROWO_W = 5;
	localparam int COLO_W = 7;
	localparam int CELL_W = 16;
	localparam int COLOR_W = 8;

	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
	localparam int TAB_STEP = 8;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_SCROLL_END,
		ST_BLANK,
		ST_DONE
	} ttce_state_t;

	// Command handed from the front to the back.
	typedef struct packed {
		logic                  do_write;
		logic                  do_read;
		logic                  do_scroll;
		logic                  do_clear;
		logic [ADDR_W_MAX-1:0] addr;
		logic [CHAR_W-1:0]     char_code;
		logic [POS_W-1:0]      cursor_pos;
		logic [ROWO_W-1:0]     cursor_row;
		logic [COLO_W-1:0]     cursor_col;
	} ttce_cmd_t;

	typedef struct packed {
		logic                  scrolled;
		logic [CELL_W-1:0]     read_cell;
		logic [COLO_W-1:0]     cursor_col;
		logic [ROWO_W-1:0]     cursor_row;
		logic [POS_W-1:0]      cursor_pos;
	} ttce_res_t;

endpackage

// File: rtl/ttce_cmd_fifo.sv
// Short command queue between the front and the back.
module ttce_cmd_fifo #(
	parameter int DEPTH = ttce_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ttce_pkg::ttce_cmd_t push_data,
	output logic                full,
	input  logic                pop,
	output ttce_pkg::ttce_cmd_t pop_data,
	output logic                empty
);
	import ttce_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ttce_cmd_t            slot_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/ttce_front.sv
// Front end: accepts items, tracks the cursor and classifies screen work.
module ttce_front #(
	parameter int COLUMNS = ttce_pkg::DEF_COLUMNS,
	parameter int ROWS    = ttce_pkg::DEF_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ttce_pkg::MODE_W-1:0]   mode,
	input  logic [ttce_pkg::CHAR_W-1:0]   char_code,
	input  logic [ttce_pkg::IDX_W-1:0]    cell_index,
	input  logic                          init_busy,
	input  logic                          fifo_full,
	output logic                          push,
	output ttce_pkg::ttce_cmd_t           push_cmd
);
	import ttce_pkg::*;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int AW     = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int COLX_W = COL_W + 1;

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [AW-1:0]     pos_q;

	logic [ROW_W-1:0]  row_n;
	logic [COL_W-1:0]  col_n;
	logic [AW-1:0]     pos_n;
	logic [COLX_W-1:0] tab_col;
	logic [COLX_W-1:0] inc_col;
	logic              newline;
	ttce_cmd_t         cmd;

	assign s_tready = !fifo_full && !init_busy;
	assign push     = s_tvalid && s_tready;

	assign tab_col = (COLX_W'(col_q) + COLX_W'(TAB_STEP)) & ~COLX_W'(TAB_STEP - 1);
	assign inc_col = COLX_W'(col_q) + COLX_W'(1);

	always_comb begin
		cmd       = '0;
		newline   = 1'b0;
		row_n     = row_q;
		col_n     = col_q;
		cmd.char_code = char_code;
		case (mode)
			MODE_PUT: begin
				case (char_code)
					CH_LF: newline = 1'b1;
					CH_CR: col_n = '0;
					CH_TAB: begin
						if (tab_col >= COLX_W'(COLUMNS)) begin
							newline = 1'b1;
						end else begin
							col_n = tab_col[COL_W-1:0];
						end
					end
					CH_BS: begin
						if (col_q != '0) begin
							col_n = col_q - COL_W'(1);
						end
					end
					default: begin
						cmd.do_write = 1'b1;
						cmd.addr     = ADDR_W_MAX'(pos_q);
						if (inc_col >= COLX_W'(COLUMNS)) begin
							newline = 1'b1;
						end else begin
							col_n = inc_col[COL_W-1:0];
						end
					end
				endcase
			end
			MODE_CLEAR: begin
				cmd.do_clear = 1'b1;
				row_n        = '0;
				col_n        = '0;
			end
			MODE_READ: begin
				cmd.do_read = (int'(cell_index) < CELLS);
				cmd.addr    = ADDR_W_MAX'(cell_index);
			end
			default: ;
		endcase
		// Move to the start of the next row; scroll at the bottom.
		if (newline) begin
			col_n = '0;
			if (row_q == ROW_W'(ROWS - 1)) begin
				cmd.do_scroll = 1'b1;
			end else begin
				row_n = row_q + ROW_W'(1);
			end
		end
		pos_n          = AW'(row_n) * AW'(COLUMNS) + AW'(col_n);
		cmd.cursor_pos = POS_W'(pos_n);
		cmd.cursor_row = ROWO_W'(row_n);
		cmd.cursor_col = COLO_W'(col_n);
	end

	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			pos_q <= '0;
		end else if (push) begin
			row_q <= row_n;
			col_q <= col_n;
			pos_q <= pos_n;
		end
	end

endmodule

// File: rtl/ttce_back.sv
// Back end: screen store, write, read, scroll and clear sweeps, result register.
module ttce_back #(
	parameter int COLUMNS = ttce_pkg::DEF_COLUMNS,
	parameter int ROWS    = ttce_pkg::DEF_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ttce_pkg::COLOR_W-1:0]   text_color,
	input  logic                           fifo_empty,
	input  ttce_pkg::ttce_cmd_t            head,
	output logic                           pop,
	output logic                           init_busy,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output ttce_pkg::ttce_res_t            res
);
	import ttce_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [AW-1:0] LAST_ADDR   = AW'(CELLS - 1);
	localparam logic [AW-1:0] BLANK_START = AW'((ROWS - 1) * COLUMNS);

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rd_data_q;

	ttce_state_t       state_q, state_n;
	logic [AW-1:0]     ptr_q;
	logic              cp_vld_s1;
	logic [AW-1:0]     cp_addr_s1;
	ttce_cmd_t         cmd_q;
	logic              m_tvalid_q;
	ttce_res_t         res_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic              load;
	logic              out_free;

	assign out_free  = !m_tvalid_q || m_tready;
	assign init_busy = (state_q == ST_INIT);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_INIT: begin
				if (ptr_q == LAST_ADDR) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!fifo_empty) begin
					if (head.do_clear) begin
						state_n = ST_BLANK;
					end else if (head.do_scroll) begin
						state_n = ST_SCROLL;
					end else begin
						state_n = ST_DONE;
					end
				end
			end
			ST_SCROLL: begin
				if (ptr_q == LAST_ADDR) begin
					state_n = ST_SCROLL_END;
				end
			end
			ST_SCROLL_END: state_n = ST_BLANK;
			ST_BLANK: begin
				if (ptr_q == LAST_ADDR) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		pop   = 1'b0;
		we    = 1'b0;
		waddr = ptr_q;
		wdata = {text_color, CH_SPACE};
		re    = 1'b0;
		raddr = ptr_q;
		load  = 1'b0;
		case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				wdata = {RESET_COLOR, CH_SPACE};
			end
			ST_IDLE: begin
				pop   = !fifo_empty;
				we    = !fifo_empty && head.do_write;
				waddr = head.addr[AW-1:0];
				wdata = {text_color, head.char_code};
				re    = !fifo_empty && head.do_read;
				raddr = head.addr[AW-1:0];
			end
			ST_SCROLL: begin
				re    = 1'b1;
				we    = cp_vld_s1;
				waddr = cp_addr_s1;
				wdata = rd_data_q;
			end
			ST_SCROLL_END: begin
				we    = 1'b1;
				waddr = cp_addr_s1;
				wdata = rd_data_q;
			end
			ST_BLANK: we = 1'b1;
			ST_DONE:  load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			ptr_q      <= '0;
			cp_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			cp_vld_s1 <= (state_q == ST_SCROLL);
			case (state_q)
				ST_INIT, ST_SCROLL, ST_BLANK: ptr_q <= ptr_q + AW'(1);
				ST_IDLE: ptr_q <= head.do_clear ? '0 : AW'(COLUMNS);
				ST_SCROLL_END: ptr_q <= BLANK_START;
				default: ;
			endcase
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= ptr_q - AW'(COLUMNS);
		if (pop) begin
			cmd_q <= head;
		end
		if (load) begin
			res_q.cursor_pos <= cmd_q.cursor_pos;
			res_q.cursor_row <= cmd_q.cursor_row;
			res_q.cursor_col <= cmd_q.cursor_col;
			res_q.read_cell  <= cmd_q.do_read ? rd_data_q : '0;
			res_q.scrolled   <= cmd_q.do_scroll;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign res      = res_q;

endmodule

// File: rtl/text_terminal_cursor_engine_unit.sv
// Top level of the text terminal cursor engine.
// An item that neither scrolls nor clears passes the queue, the back end's pop-and-execute
// state and its load state before its result is valid; the back end takes no new item
// until it has loaded the last one's result. A scroll adds a copy sweep plus a last-row
// blank; a clear adds a sweep of one cell per cycle through the single write port.
// After reset the store is swept to blanks; s_tready stays low meanwhile, while cfg writes
// are taken as usual.
module text_terminal_cursor_engine_unit #(
	parameter int COLUMNS = ttce_pkg::DEF_COLUMNS,
	parameter int ROWS    = ttce_pkg::DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [7:0] char_code, [18:8] cell_index, [23:19] zero
	input  logic [1:0]  s_tuser,  // [1:0] mode
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [10:0] cursor_pos, [15:11] cursor_row,
	                              // [22:16] cursor_col, [38:23] read_cell, [39] scrolled
	// Color register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import ttce_pkg::*;

	logic [COLOR_W-1:0] text_color_q;
	logic               init_busy;
	logic               fifo_full;
	logic               fifo_empty;
	logic               push;
	logic               pop;
	ttce_cmd_t          push_cmd;
	ttce_cmd_t          head;
	ttce_res_t          res;

	// The color register is always writable; the host must write it only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	// Front: cursor tracking and classification, one item per accept.
	ttce_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.mode       (s_tuser[MODE_W-1:0]),
		.char_code  (s_tdata[CHAR_W-1:0]),
		.cell_index (s_tdata[CHAR_W+IDX_W-1:CHAR_W]),
		.init_busy  (init_busy),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// Queue: lets the front keep taking items while the back sweeps the store.
	ttce_cmd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (fifo_full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (fifo_empty)
	);

	// Back: screen store access and the result register.
	ttce_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_color (text_color_q),
		.fifo_empty (fifo_empty),
		.head       (head),
		.pop        (pop),
		.init_busy  (init_busy),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.res        (res)
	);

	assign m_tdata = res;

endmodule

// File: sim/testbench.sv
// Testbench for the text terminal cursor engine: streamed characters checked against a cell-level screen model.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ttce_pkg::*;

	localparam int COLS    = DEF_COLUMNS;
	localparam int ROWS_N  = DEF_ROWS;
	localparam int CELLS   = COLS * ROWS_N;
	localparam int IDX_TOP = (1 << IDX_W) - 1;

	// Mode code with no function; the block must only echo the cursor.
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	// A clear or a scroll costs about one screen pass; allow ten of them back to back.
	localparam int QUIET_LIMIT = 20000;
	localparam int PHASE_ITEMS = 470;
	localparam int HOLD_CYCLES = 400;

	// Screen and cursor tracker plus the queue of cursor results still owed by the block.
	class terminal_tracker;
		logic [CELL_W-1:0]  screen [CELLS];
		int                 row;
		int                 col;
		logic [COLOR_W-1:0] color;
		ttce_res_t          expected_q[$];
		int                 errors;
		int                 results_seen;

		function new();
			foreach (screen[i]) screen[i] = {RESET_COLOR, CH_SPACE};
			row = 0;
			col = 0;
			color = RESET_COLOR;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_color(logic [COLOR_W-1:0] c);
			color = c;
		endfunction

		// Move to the start of the next row; past the bottom, shift everything up one row.
		function bit next_line();
			col = 0;
			row++;
			if (row >= ROWS_N) begin
				for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
				for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {color, CH_SPACE};
				row = ROWS_N - 1;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// Apply one accepted item and queue the result it must produce.
		function void note_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
		                        logic [IDX_W-1:0] idx);
			ttce_res_t exp_res;
			int        pos;
			exp_res = '0;
			case (mode)
				MODE_PUT: begin
					if (ch == CH_LF) begin
						exp_res.scrolled = next_line();
					end else if (ch == CH_CR) begin
						col = 0;
					end else if (ch == CH_TAB) begin
						col = (col + TAB_STEP) & ~(TAB_STEP - 1);
						if (col >= COLS) exp_res.scrolled = next_line();
					end else if (ch == CH_BS) begin
						if (col > 0) col--;
					end else begin
						screen[row * COLS + col] = {color, ch};
						col++;
						if (col >= COLS) exp_res.scrolled = next_line();
					end
				end
				MODE_CLEAR: begin
					foreach (screen[i]) screen[i] = {color, CH_SPACE};
					row = 0;
					col = 0;
				end
				MODE_READ: begin
					if (idx < CELLS) exp_res.read_cell = screen[idx];
				end
				default: ;
			endcase
			pos = row * COLS + col;
			exp_res.cursor_pos = POS_W'(pos);
			exp_res.cursor_row = ROWO_W'(row);
			exp_res.cursor_col = COLO_W'(col);
			expected_q.push_back(exp_res);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_result(ttce_res_t got);
			ttce_res_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report($sformatf("result %h with nothing pending", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.cursor_pos !== want.cursor_pos)
				report($sformatf("cursor_pos got %0d want %0d", got.cursor_pos,
				                 want.cursor_pos));
			if (got.cursor_row !== want.cursor_row)
				report($sformatf("cursor_row got %0d want %0d", got.cursor_row,
				                 want.cursor_row));
			if (got.cursor_col !== want.cursor_col)
				report($sformatf("cursor_col got %0d want %0d", got.cursor_col,
				                 want.cursor_col));
			if (got.read_cell !== want.read_cell)
				report($sformatf("read_cell got %h want %h", got.read_cell, want.read_cell));
			if (got.scrolled !== want.scrolled)
				report($sformatf("scrolled got %b want %b", got.scrolled, want.scrolled));
		endtask
	endclass

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [23:0]         s_tdata   = '0;
	logic [MODE_W-1:0]   s_tuser   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [39:0]         m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [COLOR_W-1:0]  cfg_data  = '0;

	terminal_tracker term = new();

	// Sender runs without gaps while this is set, to give stretches of full-rate input.
	bit steady_feed = 1'b0;
	int quiet_cycles = 0;

	text_terminal_cursor_engine_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 4);
		if (r < 97) return $urandom_range(5, 20);
		return $urandom_range(30, 120);
	endfunction

	// Offer one item, optionally after a gap, and hold it until the block takes it.
	// Valid stays high afterwards so that the next item can follow without a bubble.
	task automatic send_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
	                         logic [IDX_W-1:0] idx);
		int gap;
		gap = steady_feed ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {5'd0, idx, ch};
		do @(posedge clk); while (!s_tready);
		term.note_item(mode, ch, idx);
	endtask

	// Drop valid and wait for every owed result; the block is idle afterwards.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (term.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_color(logic [COLOR_W-1:0] c);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		term.set_color(c);
	endtask

	// Mostly printable text with line controls mixed in, so the cursor walks the whole
	// screen, wraps and scrolls; some reads look near the cursor to see fresh writes and
	// shifted rows, the rest go anywhere. Clears are rare: each resets the walk to the top.
	task automatic send_random_item();
		int                r;
		int                idx_val;
		logic [MODE_W-1:0] mode;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		r    = $urandom_range(0, 999);
		ch   = CHAR_W'($urandom);
		idx  = IDX_W'($urandom);
		mode = MODE_PUT;
		if (r < 3) begin
			mode = MODE_CLEAR;
		end else if (r < 25) begin
			mode = MODE_SPARE;
		end else if (r < 45) begin
			mode = MODE_READ;
			idx  = IDX_W'($urandom_range(CELLS, IDX_TOP));
		end else if (r < 95) begin
			mode = MODE_READ;
			idx_val = term.row * COLS + int'($urandom_range(0, COLS - 1));
			if (term.row > 0 && $urandom_range(0, 1) == 1) idx_val -= COLS;
			idx = IDX_W'(idx_val);
		end else if (r < 145) begin
			mode = MODE_READ;
			idx  = IDX_W'($urandom_range(0, CELLS - 1));
		end else if (r < 215) begin
			ch = CH_LF;
		end else if (r < 245) begin
			ch = CH_CR;
		end else if (r < 295) begin
			ch = CH_TAB;
		end else if (r < 345) begin
			ch = CH_BS;
		end
		send_item(mode, ch, idx);
	endtask

	// Check every result the moment it is taken; values sampled here are pre-edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) term.check_result(ttce_res_t'(m_tdata));
	end

	// Abort when no channel has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Receiver: runs of ready broken by stalls, plus one long hold-off in the middle of
	// the run so the block's queue fills and it has to push back on its input.
	initial begin
		int  stall;
		bit  held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 12)) @(posedge clk);
			stall = idle_len();
			if (!held && term.results_seen >= 600) begin
				stall = HOLD_CYCLES;
				held  = 1'b1;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		logic [COLOR_W-1:0] phase_color [4];
		phase_color[0] = 8'h00;
		phase_color[1] = 8'hFF;
		phase_color[2] = COLOR_W'($urandom_range(1, 254));
		phase_color[3] = COLOR_W'($urandom_range(1, 254));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, still in the reset color: reads of the reset screen at both ends
		// and out of range, backspace at the left edge, bytes with the top bit set, every
		// control code, the spare mode, a clear, and tabs that run off the end of a row.
		send_item(MODE_READ, 8'hFF, 11'd0);
		send_item(MODE_READ, 8'h00, IDX_W'(CELLS - 1));
		send_item(MODE_READ, 8'h00, IDX_W'(CELLS));
		send_item(MODE_READ, 8'hFF, IDX_W'(IDX_TOP));
		send_item(MODE_PUT, CH_BS, IDX_W'(IDX_TOP));
		send_item(MODE_PUT, 8'h00, 11'd0);
		send_item(MODE_PUT, 8'hFF, 11'd0);
		send_item(MODE_PUT, 8'h80, IDX_W'(IDX_TOP));
		send_item(MODE_READ, 8'h00, 11'd1);
		send_item(MODE_READ, 8'h00, 11'd2);
		send_item(MODE_PUT, CH_BS, 11'd0);
		send_item(MODE_PUT, CH_TAB, 11'd0);
		send_item(MODE_PUT, CH_CR, 11'd0);
		send_item(MODE_PUT, CH_LF, 11'd0);
		send_item(MODE_SPARE, 8'hFF, IDX_W'(IDX_TOP));
		send_item(MODE_CLEAR, 8'hFF, IDX_W'(IDX_TOP));
		// Nine tabs reach the last tab stop; the tenth wraps to the next row.
		repeat (10) send_item(MODE_PUT, CH_TAB, 11'd0);

		// Random phases, each in its own color; the block is drained before every write.
		for (int p = 0; p < 4; p++) begin
			wait_drained();
			write_color(phase_color[p]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 64 == 0) steady_feed = ($urandom_range(0, 4) == 0);
				send_random_item();
			end
		end
		steady_feed = 1'b0;

		// Let stray results show up after the last expected one.
		wait_drained();
		repeat (20) @(posedge clk);
		if (term.errors == 0 && term.expected_q.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// File: text_terminal_cursor_engine_unit.f
rtl/ttce_pkg.sv
rtl/ttce_cmd_fifo.sv
rtl/ttce_front.sv
rtl/ttce_back.sv
rtl/text_terminal_cursor_engine_unit.sv
sim/testbench.sv
